### rtl/lfu_slot_cache_controller_defines.svh
// Assertion helpers shared by the slot cache controller RTL.
// Every macro samples on the rising edge of clk and is held off during reset.
`ifndef LFU_SLOT_CACHE_CONTROLLER_DEFINES_SVH
`define LFU_SLOT_CACHE_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

  // Slot storage and key geometry.
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int MAX_LAYERS  = 64;
  localparam int MAX_EXPERTS = 256;
  localparam int LAYER_W     = 6;
  localparam int EXPERT_W    = 8;
  localparam int KEY_W       = LAYER_W + EXPERT_W;
  localparam int KEYS        = MAX_LAYERS * MAX_EXPERTS;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [DATA_W-1:0] SAT_MAX   = '1;

  // Request fields of one transfer.
  typedef struct packed {
    logic [LAYER_W-1:0]  layer;
    logic [EXPERT_W-1:0] expert;
    logic                batch_start;
  } lsc_in_t;

  // Result fields of one transfer.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill;
    logic                evicted;
    logic [LAYER_W-1:0]  evicted_layer;
    logic [EXPERT_W-1:0] evicted_expert;
    logic                no_slot;
    logic [DATA_W-1:0]   hits_total;
    logic [DATA_W-1:0]   misses_total;
  } lsc_out_t;

  // Increment that holds at the all-ones value.
  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = (v == SAT_MAX) ? v : v + DATA_W'(1);
    return r;
  endfunction

  // Usable slot count: zero acts as one, anything above SLOTS as SLOTS.
  function automatic logic [CNT_W-1:0] eff_slots(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > SLOTS_CNT) begin
      r = SLOTS_CNT;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/lfu_slot_cache_controller.sv
`timescale 1ns / 1ps
// Channel   Ports                            Transfer when
// request   start, busy, in_payload          start high and busy low at a rising edge
// result    out_strobe, out_payload          out_strobe high (one cycle, no back-pressure)
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready both high
//
// A request passes through the scan and finish states, N being the usable slot count: in
// the scan state the single key/priority comparator walks the N slots, the finish state
// commits, and in the result cycle busy is already low and the next request may be taken.
// After reset the 16384-entry frequency history is cleared one entry a cycle, with busy
// high throughout; configuration writes are taken during that pass.
// The result side cannot stall, so nothing here waits on the receiver.

`include "lfu_slot_cache_controller_defines.svh"

module lfu_slot_cache_controller
  import lsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lsc_in_t          in_payload,
  output logic             out_strobe,
  output lsc_out_t         out_payload,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r;

  // Slot table, held in flops and read at the scan index.
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  prot_r;
  logic [SLOTS-1:0]  valid_nxt;
  logic [SLOTS-1:0]  prot_nxt;
  logic [KEY_W-1:0]  key_r  [SLOTS];
  logic [DATA_W-1:0] freq_r [SLOTS];
  logic [DATA_W-1:0] last_r [SLOTS];

  // Per-key frequency history.
  logic [DATA_W-1:0] kf_mem [KEYS];
  logic [DATA_W-1:0] kf_rd_r;
  logic [KEY_W-1:0]  clr_cnt_r;

  // Global counters and the configuration register.
  logic [DATA_W-1:0] tick_r;
  logic [DATA_W-1:0] hits_r;
  logic [DATA_W-1:0] misses_r;
  logic [CNT_W-1:0]  active_r;

  // Request and search registers.
  logic [KEY_W-1:0]  req_key_r;
  logic [SLOT_W-1:0] idx_r;
  logic              hit_fnd_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic              inv_fnd_r;
  logic [SLOT_W-1:0] inv_idx_r;
  logic              have_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic [DATA_W-1:0] best_freq_r;
  logic [DATA_W-1:0] best_last_r;
  logic [KEY_W-1:0]  best_key_r;

  logic              out_strobe_r;
  lsc_out_t          out_payload_r;

  // Handshake decode.
  logic             accept;
  logic             cfg_write;
  logic [CNT_W-1:0] eff_n;
  logic [CNT_W-1:0] cfg_eff;
  logic [KEY_W-1:0] acc_key;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign eff_n     = eff_slots(active_r);
  assign cfg_eff   = eff_slots(cfg_data);
  // Layer and expert fields span exactly the layer and expert ranges, so the key is
  // their concatenation.
  assign acc_key   = {in_payload.layer, in_payload.expert};

  // Shared comparator: key match and (frequency, last use) ordering at the scan index.
  logic              sc_valid;
  logic              sc_prot;
  logic              sc_match;
  logic              sc_better;
  logic              sc_last;

  assign sc_valid  = valid_r[idx_r];
  assign sc_prot   = prot_r[idx_r];
  assign sc_match  = sc_valid && (key_r[idx_r] == req_key_r);
  assign sc_better = !have_r ||
                     ({freq_r[idx_r], last_r[idx_r]} < {best_freq_r, best_last_r});
  assign sc_last   = ({1'b0, idx_r} == (eff_n - CNT_W'(1)));

  // Commit decision.
  logic              found;
  logic              do_evict;
  logic [SLOT_W-1:0] tgt;
  logic [DATA_W-1:0] freq_new;
  logic [DATA_W-1:0] hits_nxt;
  logic [DATA_W-1:0] misses_nxt;

  always_comb begin
    found    = hit_fnd_r || inv_fnd_r || have_r;
    do_evict = !hit_fnd_r && !inv_fnd_r && have_r;
    if (hit_fnd_r) begin
      tgt = hit_idx_r;
    end else if (inv_fnd_r) begin
      tgt = inv_idx_r;
    end else begin
      tgt = best_idx_r;
    end
    freq_new   = sat_inc(kf_rd_r);
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (found) begin
      if (hit_fnd_r) begin
        hits_nxt = sat_inc(hits_r);
      end else begin
        misses_nxt = sat_inc(misses_r);
      end
    end
  end

  // Sequencer, counters and search registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      tick_r       <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      active_r     <= SLOTS_CNT;
      idx_r        <= '0;
      hit_fnd_r    <= 1'b0;
      inv_fnd_r    <= 1'b0;
      have_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_FINISH);
      if (cfg_write) begin
        active_r <= cfg_data;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + KEY_W'(1);
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_r   <= ST_SCAN;
            idx_r     <= '0;
            hit_fnd_r <= 1'b0;
            inv_fnd_r <= 1'b0;
            have_r    <= 1'b0;
            if (in_payload.batch_start) begin
              tick_r <= sat_inc(tick_r);
            end
          end
        end
        ST_SCAN: begin
          if (!hit_fnd_r && sc_match) begin
            hit_fnd_r <= 1'b1;
          end
          if (!inv_fnd_r && !sc_valid) begin
            inv_fnd_r <= 1'b1;
          end
          if (sc_valid && !sc_prot && sc_better) begin
            have_r <= 1'b1;
          end
          idx_r <= idx_r + SLOT_W'(1);
          if (sc_last) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          hits_r   <= hits_nxt;
          misses_r <= misses_nxt;
          state_r  <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Search payload registers, captured alongside their found flags.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_key_r <= acc_key;
    end
    if (state_r == ST_SCAN) begin
      if (!hit_fnd_r && sc_match) begin
        hit_idx_r <= idx_r;
      end
      if (!inv_fnd_r && !sc_valid) begin
        inv_idx_r <= idx_r;
      end
      if (sc_valid && !sc_prot && sc_better) begin
        best_idx_r  <= idx_r;
        best_freq_r <= freq_r[idx_r];
        best_last_r <= last_r[idx_r];
        best_key_r  <= key_r[idx_r];
      end
    end
  end

  // Slot valid and protect bits: config trims, batch start unprotects, commit sets.
  always_comb begin
    valid_nxt = valid_r;
    prot_nxt  = prot_r;
    if (cfg_write) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (CNT_W'(s) >= cfg_eff) begin
          valid_nxt[s] = 1'b0;
          prot_nxt[s]  = 1'b0;
        end
      end
    end
    if (accept && in_payload.batch_start) begin
      prot_nxt = '0;
    end
    if ((state_r == ST_FINISH) && found) begin
      valid_nxt[tgt] = 1'b1;
      prot_nxt[tgt]  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      prot_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      prot_r  <= prot_nxt;
    end
  end

  // Slot contents; an invalid slot is never consulted, so these need no reset.
  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && found) begin
      key_r[tgt]  <= req_key_r;
      freq_r[tgt] <= freq_new;
      last_r[tgt] <= tick_r;
    end
  end

  // Frequency history: zeroing pass after reset, read-modify-write per request.
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      kf_mem[clr_cnt_r] <= '0;
    end else if ((state_r == ST_FINISH) && found) begin
      kf_mem[req_key_r] <= freq_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kf_rd_r <= kf_mem[acc_key];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      out_payload_r.slot           <= found ? tgt : '0;
      out_payload_r.hit            <= found && hit_fnd_r;
      out_payload_r.fill           <= found && !hit_fnd_r;
      out_payload_r.evicted        <= do_evict;
      out_payload_r.evicted_layer  <= do_evict ? best_key_r[KEY_W-1:EXPERT_W] : '0;
      out_payload_r.evicted_expert <= do_evict ? best_key_r[EXPERT_W-1:0] : '0;
      out_payload_r.no_slot        <= !found;
      out_payload_r.hits_total     <= hits_nxt;
      out_payload_r.misses_total   <= misses_nxt;
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_payload_r;

  // Checks on the sequencer and the result encoding.
  `LSC_ASSERT_NEXT(a_commit_strobes, state_r == ST_FINISH, out_strobe, "commit without result")
  `LSC_ASSERT_SAME(a_scan_in_range, state_r == ST_SCAN, {1'b0, idx_r} < eff_n,
                   "scan index past usable slots")
  `LSC_ASSERT_SAME(a_noslot_quiet, out_strobe && out_payload.no_slot,
                   !out_payload.hit && !out_payload.fill && !out_payload.evicted,
                   "no_slot result carries a placement")
  `LSC_ASSERT_SAME(a_hit_xor_fill, out_strobe && !out_payload.no_slot,
                   out_payload.hit != out_payload.fill, "hit and fill not exclusive")
  `LSC_ASSERT_NEXT(a_accept_busy, accept, busy && !out_strobe, "accept did not start work")

endmodule

### test/lfu_slot_cache_controller_test.sv
`timescale 1ns / 1ps

module lfu_slot_cache_controller_test;
  import lsc_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned IDLE_LIMIT = 70000;
  localparam int unsigned PHASE_ITEMS = 150;

  // Mirror of the slot cache: its own copy of the slots, the per-key
  // frequency history and the totals, plus the outcomes still owed by the block.
  class slot_cache_mirror;
    bit [CNT_W-1:0]  active_slots;
    bit              valid [SLOTS];
    bit [KEY_W-1:0]  keys [SLOTS];
    bit [DATA_W-1:0] freq [SLOTS];
    bit [DATA_W-1:0] last [SLOTS];
    bit              guarded [SLOTS];
    bit [DATA_W-1:0] history [KEYS];
    bit [DATA_W-1:0] tick;
    bit [DATA_W-1:0] hit_count;
    bit [DATA_W-1:0] miss_count;
    lsc_out_t        owed_outcomes [$];
    int unsigned     failures;

    function new();
      active_slots = CNT_W'(SLOTS);
      for (int s = 0; s < SLOTS; s++) begin
        forget_slot(s);
      end
      tick = '0;
      hit_count = '0;
      miss_count = '0;
      failures = 0;
    endfunction

    // Counters stop at all ones.
    function bit [DATA_W-1:0] bump(bit [DATA_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void forget_slot(int s);
      valid[s] = 1'b0;
      keys[s] = '0;
      freq[s] = '0;
      last[s] = '0;
      guarded[s] = 1'b0;
    endfunction

    // Zero acts as one slot, anything above the slot count as the slot count.
    function int unsigned usable();
      if (active_slots == 0) return 1;
      if (active_slots > SLOTS) return SLOTS;
      return active_slots;
    endfunction

    // A register write drops every slot outside the new usable range.
    function void set_active_slots(bit [CNT_W-1:0] v);
      active_slots = v;
      for (int s = usable(); s < SLOTS; s++) begin
        forget_slot(s);
      end
    endfunction

    // Work out the outcome of one accepted request and update the mirror.
    function void note_request(lsc_in_t req);
      bit [KEY_W-1:0] key;
      int unsigned n;
      int unsigned tgt;
      bit found;
      bit hit;
      bit have;
      lsc_out_t res;
      key = {req.layer, req.expert};
      n = usable();
      tgt = 0;
      found = 1'b0;
      hit = 1'b0;
      have = 1'b0;
      res = '0;
      if (req.batch_start) begin
        tick = bump(tick);
        for (int s = 0; s < SLOTS; s++) begin
          guarded[s] = 1'b0;
        end
      end
      // Lookup first, then the lowest empty slot, then the cheapest victim.
      for (int unsigned s = 0; s < n && !found; s++) begin
        if (valid[s] && keys[s] == key) begin
          tgt = s;
          found = 1'b1;
          hit = 1'b1;
        end
      end
      for (int unsigned s = 0; s < n && !found; s++) begin
        if (!valid[s]) begin
          tgt = s;
          found = 1'b1;
        end
      end
      if (!found) begin
        for (int unsigned s = 0; s < n; s++) begin
          if (!guarded[s] && (!have || freq[s] < freq[tgt] ||
              (freq[s] == freq[tgt] && last[s] < last[tgt]))) begin
            tgt = s;
            have = 1'b1;
          end
        end
      end
      if (!found && !have) begin
        // Every usable slot is protected: nothing but the batch effects change.
        res.no_slot = 1'b1;
      end else begin
        history[key] = bump(history[key]);
        if (hit) begin
          hit_count = bump(hit_count);
        end else begin
          miss_count = bump(miss_count);
        end
        res.slot = SLOT_W'(tgt);
        res.hit = hit;
        res.fill = !hit;
        res.evicted = have;
        if (have) begin
          {res.evicted_layer, res.evicted_expert} = keys[tgt];
        end
        valid[tgt] = 1'b1;
        keys[tgt] = key;
        freq[tgt] = history[key];
        last[tgt] = tick;
        guarded[tgt] = 1'b1;
      end
      res.hits_total = hit_count;
      res.misses_total = miss_count;
      owed_outcomes = {owed_outcomes, res};
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    // Compare one result transfer with the oldest outcome owed.
    function void check_outcome(lsc_out_t got);
      lsc_out_t want;
      if (owed_outcomes.size() == 0) begin
        $error("result transfer with no request outstanding: 0x%0h", got);
        failures++;
        return;
      end
      want = owed_outcomes.pop_front();
      check_field("slot", want.slot, got.slot);
      check_field("hit", want.hit, got.hit);
      check_field("fill", want.fill, got.fill);
      check_field("evicted", want.evicted, got.evicted);
      check_field("evicted_layer", want.evicted_layer, got.evicted_layer);
      check_field("evicted_expert", want.evicted_expert, got.evicted_expert);
      check_field("no_slot", want.no_slot, got.no_slot);
      check_field("hits_total", want.hits_total, got.hits_total);
      check_field("misses_total", want.misses_total, got.misses_total);
    endfunction

    function int unsigned outstanding();
      return owed_outcomes.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  lsc_in_t          in_payload;
  logic             out_strobe;
  lsc_out_t         out_payload;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  slot_cache_mirror mirror;
  int unsigned      burst_left;
  int unsigned      stalled_cycles;

  lfu_slot_cache_controller u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_strobe  (out_strobe),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results cannot be held off, so every strobe is a transfer to check.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      mirror.check_outcome(out_payload);
    end
  end

  // Hang detection: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("** lfu_slot_cache_controller: FAILED **");
      $finish;
    end
  end

  function automatic lsc_in_t make_request(int unsigned layer, int unsigned expert, bit first);
    lsc_in_t req;
    req.layer = LAYER_W'(layer);
    req.expert = EXPERT_W'(expert);
    req.batch_start = first;
    return req;
  endfunction

  // Hold one request until the block takes it.
  task automatic issue(lsc_in_t req);
    in_payload <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.note_request(req);
  endtask

  task automatic wait_drained();
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  // Sender works in bursts; between bursts it idles or waits for the block to drain.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25);
      if ($urandom_range(0, 29) == 0) begin
        start <= 1'b0;
        @(posedge clk);
        wait_drained();
      end else if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_active_slots(logic [CNT_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    mirror.set_active_slots(v);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every result come back, then change the slot count.
  task automatic reconfigure(logic [CNT_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    wait_drained();
    write_active_slots(v);
  endtask

  // Two slots: fills, a hit, a fully protected batch, evictions by frequency,
  // by index on a full tie and by last use on a frequency tie, and key extremes.
  task automatic run_directed();
    issue(make_request(63, 255, 1));
    issue(make_request(0, 0, 0));
    issue(make_request(63, 255, 0));
    issue(make_request(42, 85, 0));
    issue(make_request(42, 85, 1));
    issue(make_request(21, 170, 0));
    issue(make_request(63, 255, 1));
    issue(make_request(42, 85, 0));
    issue(make_request(21, 170, 1));
    issue(make_request(0, 0, 0));
    issue(make_request(0, 0, 1));
    issue(make_request(21, 170, 1));
    issue(make_request(42, 85, 1));
    issue(make_request(63, 0, 0));
    issue(make_request(0, 255, 0));
    issue(make_request(0, 255, 1));
    issue(make_request(63, 0, 0));
    issue(make_request(63, 0, 0));
  endtask

  // Batches drawn mostly from a small key pool so that hits, evictions and
  // fully protected batches are common; the rest is random keys and stray
  // or missing batch starts.
  task automatic run_phase(int unsigned count);
    bit [KEY_W-1:0] pool [$];
    bit [KEY_W-1:0] key;
    int unsigned n;
    int unsigned left_in_batch;
    bit first;
    n = mirror.usable();
    repeat ($urandom_range(n, 2 * n + 2)) pool = {pool, KEY_W'($urandom_range(0, KEYS - 1))};
    left_in_batch = 0;
    repeat (count) begin
      if (left_in_batch == 0) begin
        left_in_batch = $urandom_range(1, n + 3);
        first = ($urandom_range(0, 9) != 0);
      end else begin
        first = ($urandom_range(0, 31) == 0);
      end
      left_in_batch--;
      if ($urandom_range(0, 7) == 0) begin
        key = KEY_W'($urandom_range(0, KEYS - 1));
      end else begin
        key = pool[$urandom_range(0, pool.size() - 1)];
      end
      pace_sender();
      issue(make_request(key[KEY_W-1:EXPERT_W], key[EXPERT_W-1:0], first));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] settings [9];
    settings = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd7, 5'd17, 5'd3, 5'd12, 5'd16};
    mirror = new();
    burst_left = 0;
    stalled_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_payload = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The register transfer is taken during the clearing pass after reset.
    write_active_slots(5'd2);
    run_directed();
    foreach (settings[i]) begin
      reconfigure(settings[i]);
      run_phase(PHASE_ITEMS);
    end

    start <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mirror.failures == 0 && mirror.outstanding() == 0) begin
      $display("** lfu_slot_cache_controller: PASSED **");
    end else begin
      $display("** lfu_slot_cache_controller: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lsc_pkg.sv
rtl/lfu_slot_cache_controller.sv
test/lfu_slot_cache_controller_test.sv
